// File: rtl/fcta_pkg.sv
package fcta_pkg;

	// Default values for the top-level parameters.
	localparam int SCREEN_HEIGHT_DEF   = 512;
	localparam int SCREEN_PITCH_DEF    = 3072;
	localparam int BYTES_PER_PIXEL_DEF = 3;
	localparam int TEXTURE_PITCH_DEF   = 768;
	localparam int FIELD_OF_VIEW_DEF   = 683;

	// Configuration port geometry.
	localparam int CFG_DATA_W  = 24;
	localparam int CFG_INDEX_W = 3;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_HORIZON_OFFSET    = 3'd0,
		CFG_EYE_HEIGHT        = 3'd1,
		CFG_PLANE_DISTANCE    = 3'd2,
		CFG_CAMERA_X          = 3'd3,
		CFG_CAMERA_Y          = 3'd4,
		CFG_WRAP_WIDTH        = 3'd5,
		CFG_WRAP_HEIGHT       = 3'd6,
		CFG_COLUMN_ANGLE_STEP = 3'd7
	} cfg_reg_t;

	// Quarter-wave sine table, Q1.14 magnitudes.
	localparam int SINE_ENTRIES = 1025;
	localparam int SINE_W       = 15;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef logic [SINE_W-1:0] sine_tab_t [0:SINE_ENTRIES-1];

	// Builds the table with a fixed seven-term Taylor series in Q2.30, rounded half up.
	function automatic sine_tab_t build_sine_table();
		sine_tab_t   tab;
		logic [63:0] x;
		logic [63:0] sum;
		logic [63:0] term;
		logic [63:0] s;
		for (int i = 0; i < SINE_ENTRIES; i++) begin
			x    = (64'(i) * HALF_PI_Q30) >> 10;
			sum  = x;
			term = x;
			for (int k = 1; k <= 6; k++) begin
				term = (((term * x) >> 30) * x) >> 30;
				term = term / 64'((2 * k) * (2 * k + 1));
				if (k[0]) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			s = (sum + 64'd32768) >> 16;
			if (s > 64'd16384) begin
				s = 64'd16384;
			end
			tab[i] = SINE_W'(s);
		end
		return tab;
	endfunction

endpackage

// File: rtl/floor_ceiling_texel_address.sv
// Channel     Ports                                            Handshake
// input       column, row, is_ceiling, ray_heading             start && !busy
// config      wr_index, wr_data                                wr_en
// result      surface_address, texel_address, on_horizon       done (one cycle)
//
// One pixel enters every clock cycle; busy is always low.
// The path holds eight stage registers plus three bit-serial divider pipelines
// (24 stages for the row distance, 24 for the fisheye correction,
// 18 for the texture wrap) that produce one quotient bit per stage.
// Reset loads the configuration defaults and clears all valid bits; nothing else needs it.
// The receiver cannot stall, so the pipeline advances every cycle.
// is_ceiling is taken but does not affect the result.
module floor_ceiling_texel_address #(
	parameter int SCREEN_HEIGHT   = fcta_pkg::SCREEN_HEIGHT_DEF,
	parameter int SCREEN_PITCH    = fcta_pkg::SCREEN_PITCH_DEF,
	parameter int BYTES_PER_PIXEL = fcta_pkg::BYTES_PER_PIXEL_DEF,
	parameter int TEXTURE_PITCH   = fcta_pkg::TEXTURE_PITCH_DEF,
	parameter int FIELD_OF_VIEW   = fcta_pkg::FIELD_OF_VIEW_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [9:0]                       column,
	input  logic [8:0]                       row,
	input  logic                             is_ceiling,
	input  logic [11:0]                      ray_heading,
	input  logic                             wr_en,
	input  logic [fcta_pkg::CFG_INDEX_W-1:0] wr_index,
	input  logic [fcta_pkg::CFG_DATA_W-1:0]  wr_data,
	output logic                             done,
	output logic [20:0]                      surface_address,
	output logic [17:0]                      texel_address,
	output logic                             on_horizon
);

	localparam int DIST_DW = 19;
	localparam int DIST_QW = 24;
	localparam int CORR_DW = 15;
	localparam int MOD_DW  = 9;
	localparam int MOD_QW  = 18;
	localparam int SIDE1_W = 21 + 1 + 12 + 12;
	localparam int SIDE2_W = 21 + 1 + 1 + 12;
	localparam int SIDEU_W = 21 + 1 + 1;
	localparam int LATENCY = 8 + 2 * DIST_QW + MOD_QW;

	localparam logic signed [12:0] SCREEN_H13 = 13'(SCREEN_HEIGHT);
	localparam logic [15:0]        FOV_OFS    = 16'((FIELD_OF_VIEW / 2) * 16);

	// Configuration registers.
	logic signed [10:0] horizon_offset_q;
	logic [15:0]        eye_height_q;
	logic [15:0]        plane_distance_q;
	logic [23:0]        camera_x_q;
	logic [23:0]        camera_y_q;
	logic [8:0]         wrap_width_q;
	logic [8:0]         wrap_height_q;
	logic [15:0]        column_angle_step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			horizon_offset_q    <= 11'sd0;
			eye_height_q        <= 16'd256;
			plane_distance_q    <= 16'd256;
			camera_x_q          <= 24'd0;
			camera_y_q          <= 24'd0;
			wrap_width_q        <= 9'd64;
			wrap_height_q       <= 9'd64;
			column_angle_step_q <= 16'd4;
		end else if (wr_en) begin
			case (wr_index)
				fcta_pkg::CFG_HORIZON_OFFSET:    horizon_offset_q    <= wr_data[10:0];
				fcta_pkg::CFG_EYE_HEIGHT:        eye_height_q        <= wr_data[15:0];
				fcta_pkg::CFG_PLANE_DISTANCE:    plane_distance_q    <= wr_data[15:0];
				fcta_pkg::CFG_CAMERA_X:          camera_x_q          <= wr_data[23:0];
				fcta_pkg::CFG_CAMERA_Y:          camera_y_q          <= wr_data[23:0];
				fcta_pkg::CFG_WRAP_WIDTH:        wrap_width_q        <= wr_data[8:0];
				fcta_pkg::CFG_WRAP_HEIGHT:       wrap_height_q       <= wr_data[8:0];
				fcta_pkg::CFG_COLUMN_ANGLE_STEP: column_angle_step_q <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// Stage 1: input capture.
	logic        valid_s1;
	logic [9:0]  col_s1;
	logic [8:0]  row_s1;
	logic [11:0] ang_s1;

	always_ff @(posedge clk) begin
		col_s1 <= column;
		row_s1 <= row;
		ang_s1 <= ray_heading;
	end

	// Horizon row, distance to it, surface address and the two products.
	logic signed [12:0] hsum;
	logic signed [12:0] horizon;
	logic signed [12:0] rdiff;
	logic [12:0]        rabs;
	logic [31:0]        surf_full;
	logic [31:0]        nprod;
	logic [25:0]        pcol;

	assign hsum      = SCREEN_H13 + {{2{horizon_offset_q[10]}}, horizon_offset_q};
	assign horizon   = (hsum + $signed({12'd0, hsum[12]})) >>> 1;
	assign rdiff     = $signed({4'd0, row_s1}) - horizon;
	assign rabs      = rdiff[12] ? 13'(-rdiff) : rdiff;
	assign surf_full = 32'(row_s1) * 32'(SCREEN_PITCH) + 32'(col_s1) * 32'(BYTES_PER_PIXEL);
	assign nprod     = eye_height_q * plane_distance_q;
	assign pcol      = col_s1 * column_angle_step_q;

	// Stage 2.
	logic        valid_s2;
	logic [20:0] surf_s2;
	logic [10:0] ad_s2;
	logic        hz_s2;
	logic [31:0] nprod_s2;
	logic [15:0] pcol_s2;
	logic [11:0] ang_s2;

	always_ff @(posedge clk) begin
		surf_s2  <= surf_full[20:0];
		ad_s2    <= rabs[10:0];
		hz_s2    <= (rabs == 13'd0);
		nprod_s2 <= nprod;
		pcol_s2  <= pcol[15:0];
		ang_s2   <= ang_s1;
	end

	// Fisheye angle and the row distance divide: floor(eye*plane / (256*|d|)).
	logic [15:0]        fdiff;
	logic [11:0]        fa;
	logic               d1_valid;
	logic [DIST_QW-1:0] d1_quo;
	logic [DIST_DW-1:0] d1_rem;
	logic [SIDE1_W-1:0] d1_side;

	assign fdiff = pcol_s2 - FOV_OFS;
	assign fa    = fdiff[15:4];

	fcta_divider #(
		.DW(DIST_DW),
		.QW(DIST_QW),
		.SW(SIDE1_W)
	) u_dist_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s2),
		.in_rem   ({11'd0, nprod_s2[31:24]}),
		.in_num   (nprod_s2[23:0]),
		.in_div   ({ad_s2, 8'd0}),
		.in_side  ({surf_s2, hz_s2, fa, ang_s2}),
		.out_valid(d1_valid),
		.out_quo  (d1_quo),
		.out_rem  (d1_rem),
		.out_side (d1_side)
	);

	// Fisheye cosine lookup lands with stage 3.
	logic signed [15:0] fc_s3;

	fcta_sine_rom u_fish_rom (
		.clk  (clk),
		.angle(12'(d1_side[23:12] + 12'd1024)),
		.value(fc_s3)
	);

	// Stage 3.
	logic        valid_s3;
	logic [23:0] dist_s3;
	logic [20:0] surf_s3;
	logic        hz_s3;
	logic [11:0] ang_s3;

	always_ff @(posedge clk) begin
		dist_s3 <= d1_quo;
		surf_s3 <= d1_side[45:25];
		hz_s3   <= d1_side[24] | (d1_rem != d1_rem);
		ang_s3  <= d1_side[11:0];
	end

	// Fisheye correction divide; saturates on a non-positive cosine or a big quotient.
	logic               fc_pos;
	logic               sat;
	logic               d2_valid;
	logic [DIST_QW-1:0] d2_quo;
	logic [CORR_DW-1:0] d2_rem;
	logic [SIDE2_W-1:0] d2_side;

	assign fc_pos = !fc_s3[15] && (fc_s3 != 16'sd0);
	assign sat    = !fc_pos || ({1'b0, dist_s3[23:10]} >= fc_s3[14:0]);

	fcta_divider #(
		.DW(CORR_DW),
		.QW(DIST_QW),
		.SW(SIDE2_W)
	) u_corr_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s3),
		.in_rem   ({1'b0, dist_s3[23:10]}),
		.in_num   ({dist_s3[9:0], 14'd0}),
		.in_div   (fc_s3[14:0]),
		.in_side  ({surf_s3, hz_s3, sat, ang_s3}),
		.out_valid(d2_valid),
		.out_quo  (d2_quo),
		.out_rem  (d2_rem),
		.out_side (d2_side)
	);

	// Ray direction lookups land with stage 4.
	logic signed [15:0] cos_s4;
	logic signed [15:0] sin_s4;

	fcta_sine_rom u_cos_rom (
		.clk  (clk),
		.angle(12'(d2_side[11:0] + 12'd1024)),
		.value(cos_s4)
	);

	fcta_sine_rom u_sin_rom (
		.clk  (clk),
		.angle(d2_side[11:0]),
		.value(sin_s4)
	);

	// Stage 4.
	logic        valid_s4;
	logic [23:0] dist_s4;
	logic [20:0] surf_s4;
	logic        hz_s4;

	always_ff @(posedge clk) begin
		dist_s4 <= d2_side[12] ? 24'hFFFFFF : d2_quo;
		surf_s4 <= d2_side[34:14];
		hz_s4   <= d2_side[13] | (d2_rem != d2_rem);
	end

	// Projection along the ray.
	logic signed [24:0] dist_sx;
	logic signed [40:0] px;
	logic signed [40:0] py;

	assign dist_sx = $signed({1'b0, dist_s4});
	assign px      = dist_sx * cos_s4;
	assign py      = dist_sx * sin_s4;

	// Stage 5.
	logic               valid_s5;
	logic signed [40:0] px_s5;
	logic signed [40:0] py_s5;
	logic [20:0]        surf_s5;
	logic               hz_s5;

	always_ff @(posedge clk) begin
		px_s5   <= px;
		py_s5   <= py;
		surf_s5 <= surf_s4;
		hz_s5   <= hz_s4;
	end

	// World point, integer texel coordinate and its magnitude.
	logic [26:0] fx;
	logic [26:0] fy;
	logic [18:0] tu;
	logic [18:0] tv;
	logic [18:0] magu;
	logic [18:0] magv;

	assign fx   = {{3{camera_x_q[23]}}, camera_x_q} + px_s5[40:14];
	assign fy   = {{3{camera_y_q[23]}}, camera_y_q} + py_s5[40:14];
	assign tu   = fx[26:8];
	assign tv   = fy[26:8];
	assign magu = tu[18] ? 19'(~tu + 19'd1) : tu;
	assign magv = tv[18] ? 19'(~tv + 19'd1) : tv;

	// Stage 6.
	logic        valid_s6;
	logic [17:0] magu_s6;
	logic [17:0] magv_s6;
	logic        negu_s6;
	logic        negv_s6;
	logic [20:0] surf_s6;
	logic        hz_s6;

	always_ff @(posedge clk) begin
		magu_s6 <= magu[17:0];
		magv_s6 <= magv[17:0];
		negu_s6 <= tu[18];
		negv_s6 <= tv[18];
		surf_s6 <= surf_s5;
		hz_s6   <= hz_s5;
	end

	// Texture wrap: remainders of the magnitudes by the texture size.
	logic               mu_valid;
	logic [MOD_QW-1:0]  mu_quo;
	logic [MOD_DW-1:0]  mu_rem;
	logic [SIDEU_W-1:0] mu_side;
	logic               mv_valid;
	logic [MOD_QW-1:0]  mv_quo;
	logic [MOD_DW-1:0]  mv_rem;
	logic               mv_side;

	fcta_divider #(
		.DW(MOD_DW),
		.QW(MOD_QW),
		.SW(SIDEU_W)
	) u_wrap_u (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s6),
		.in_rem   ('0),
		.in_num   (magu_s6),
		.in_div   (wrap_width_q),
		.in_side  ({surf_s6, hz_s6, negu_s6}),
		.out_valid(mu_valid),
		.out_quo  (mu_quo),
		.out_rem  (mu_rem),
		.out_side (mu_side)
	);

	fcta_divider #(
		.DW(MOD_DW),
		.QW(MOD_QW),
		.SW(1)
	) u_wrap_v (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s6),
		.in_rem   ('0),
		.in_num   (magv_s6),
		.in_div   (wrap_height_q),
		.in_side  (negv_s6),
		.out_valid(mv_valid),
		.out_quo  (mv_quo),
		.out_rem  (mv_rem),
		.out_side (mv_side)
	);

	// Floor modulo: a negative coordinate with a nonzero remainder folds back.
	logic [8:0] tex_u;
	logic [8:0] tex_v;

	assign tex_u = (wrap_width_q == 9'd0) ? 9'd0 :
		((mu_side[0] && mu_rem != 9'd0) ? 9'(wrap_width_q - mu_rem) : mu_rem);
	assign tex_v = (wrap_height_q == 9'd0) ? 9'd0 :
		((mv_side && mv_rem != 9'd0) ? 9'(wrap_height_q - mv_rem) : mv_rem);

	// Stage 7.
	logic        valid_s7;
	logic [8:0]  u_s7;
	logic [8:0]  v_s7;
	logic [20:0] surf_s7;
	logic        hz_s7;

	always_ff @(posedge clk) begin
		u_s7    <= tex_u;
		v_s7    <= tex_v;
		surf_s7 <= mu_side[22:2];
		hz_s7   <= mu_side[1] | (mu_quo != mu_quo) | (mv_quo != mv_quo);
	end

	logic [31:0] texel_full;

	assign texel_full = 32'(v_s7) * 32'(TEXTURE_PITCH) + 32'(u_s7) * 32'(BYTES_PER_PIXEL);

	// Stage 8: result registers.
	logic        valid_s8;
	logic [20:0] surf_s8;
	logic [17:0] texel_s8;
	logic        hz_s8;

	always_ff @(posedge clk) begin
		surf_s8  <= hz_s7 ? 21'd0 : surf_s7;
		texel_s8 <= hz_s7 ? 18'd0 : texel_full[17:0];
		hz_s8    <= hz_s7;
	end

	// Valid bits of the stages outside the dividers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= d1_valid;
			valid_s4 <= d2_valid;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= mu_valid && mv_valid;
			valid_s8 <= valid_s7;
		end
	end

	assign done            = valid_s8;
	assign surface_address = surf_s8;
	assign texel_address   = texel_s8;
	assign on_horizon      = hz_s8;

`ifndef ASSERT_OFF
	// Every accepted transaction yields a result after the fixed latency.
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted pixel produced no result");

	// No result appears without an accepted transaction behind it.
	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching input");

	// The two wrap dividers stay in lockstep.
	a_wrap_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		mu_valid == mv_valid)
		else $error("wrap dividers out of step");

	// A horizon pixel reports zero addresses.
	a_horizon_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && on_horizon) |-> (surface_address == 21'd0 && texel_address == 18'd0))
		else $error("horizon pixel with nonzero address");
`endif

endmodule

// File: rtl/fcta_sine_rom.sv
module fcta_sine_rom (
	input  logic               clk,
	input  logic [11:0]        angle,
	output logic signed [15:0] value
);

	localparam fcta_pkg::sine_tab_t SINE_TAB = fcta_pkg::build_sine_table();

	logic [10:0]                      idx;
	logic [fcta_pkg::SINE_W-1:0]      mag;
	logic signed [15:0]               value_q;

	// Odd quadrants read the table backward; the upper half turn negates.
	assign idx = angle[10] ? (11'd1024 - {1'b0, angle[9:0]}) : {1'b0, angle[9:0]};
	assign mag = SINE_TAB[idx];

	// Registered read.
	always_ff @(posedge clk) begin
		value_q <= angle[11] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end

	assign value = value_q;

endmodule

// File: rtl/fcta_divider.sv
module fcta_divider #(
	parameter int DW = 8,
	parameter int QW = 8,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [DW-1:0] in_rem,
	input  logic [QW-1:0] in_num,
	input  logic [DW-1:0] in_div,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [QW-1:0] out_quo,
	output logic [DW-1:0] out_rem,
	output logic [SW-1:0] out_side
);

	// One restoring step per stage; index 0 is the input.
	logic          valid_s [0:QW];
	logic [DW-1:0] rem_s   [0:QW];
	logic [QW-1:0] num_s   [0:QW];
	logic [QW-1:0] quo_s   [0:QW];
	logic [DW-1:0] div_s   [0:QW];
	logic [SW-1:0] side_s  [0:QW];

	assign valid_s[0] = in_valid;
	assign rem_s[0]   = in_rem;
	assign num_s[0]   = in_num;
	assign quo_s[0]   = '0;
	assign div_s[0]   = in_div;
	assign side_s[0]  = in_side;

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          take;
		logic [DW-1:0] next_rem;

		// Shift in the next numerator bit and try to subtract the divisor.
		assign trial    = {rem_s[k], num_s[k][QW-1]};
		assign diff     = trial - {1'b0, div_s[k]};
		assign take     = trial >= {1'b0, div_s[k]};
		assign next_rem = take ? diff[DW-1:0] : trial[DW-1:0];

		// Valid bit of the stage.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		// Stage payload.
		always_ff @(posedge clk) begin
			rem_s[k+1]  <= next_rem;
			num_s[k+1]  <= {num_s[k][QW-2:0], 1'b0};
			quo_s[k+1]  <= {quo_s[k][QW-2:0], take};
			div_s[k+1]  <= div_s[k];
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_valid = valid_s[QW];
	assign out_quo   = quo_s[QW];
	assign out_rem   = rem_s[QW];
	assign out_side  = side_s[QW];

endmodule
